@@ sv/binary_max_heap_queue_top_defines.svh @@
// assertion macros used by the heap queue datapath
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH

// same-cycle implication on i_clk, off while i_rst_n is low
`define BMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, off while i_rst_n is low
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bmhq_pkg.sv @@
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int CAPACITY  = 64;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int IDX_W     = ADDR_W + 2;
    localparam int PAY_W     = 32;
    localparam int PRI_W     = 16;
    localparam int ENTRY_W   = PAY_W + PRI_W;
    localparam int OUT_CNT_W = 7;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    command;
        logic [PAY_W-1:0]        payload;
        logic signed [PRI_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic                    top_valid;
        logic [PAY_W-1:0]        top_payload;
        logic signed [PRI_W-1:0] top_priority;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic [PAY_W-1:0]        pay;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_LAST_RD,
        S_POP_LAST_WAIT,
        S_POP_CHK,
        S_POP_R_RD,
        S_POP_CMP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_MOV,
        WR_PARENT,
        WR_CHILD
    } t_wr_sel;

    typedef struct packed {
        logic    accept;
        logic    start_push;
        logic    start_pop;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    load_mov;
        logic    load_left;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_push;
        logic full;
        logic empty;
        logic pos_zero;
        logic parent_wins;
        logic no_left;
        logic child_wins;
        logic out_free;
    } t_dp_sts;

endpackage

@@ sv/bmhq_ram.sv @@
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bmhq_ctrl.sv @@
`timescale 1ns / 1ps

module bmhq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output bmhq_pkg::t_dp_cmd o_cmd,
    input  bmhq_pkg::t_dp_sts i_sts
);

    import bmhq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.is_push) begin
                        n_state = i_sts.full ? S_DONE : S_PUSH_CHK;
                    end else begin
                        n_state = i_sts.empty ? S_DONE : S_POP_LAST_RD;
                    end
                end
            end
            S_PUSH_CHK:      n_state = i_sts.pos_zero ? S_DONE : S_PUSH_CMP;
            S_PUSH_CMP:      n_state = i_sts.parent_wins ? S_DONE : S_PUSH_CHK;
            S_POP_LAST_RD:   n_state = i_sts.empty ? S_DONE : S_POP_LAST_WAIT;
            S_POP_LAST_WAIT: n_state = S_POP_CHK;
            S_POP_CHK:       n_state = i_sts.no_left ? S_DONE : S_POP_R_RD;
            S_POP_R_RD:      n_state = S_POP_CMP;
            S_POP_CMP:       n_state = i_sts.child_wins ? S_POP_CHK : S_DONE;
            S_DONE:          n_state = i_sts.out_free ? S_IDLE : S_DONE;
            default:         n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_NONE;
        o_cmd.wr_sel = WR_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.accept     = i_valid;
                o_cmd.start_push = i_valid && i_sts.is_push && !i_sts.full;
                o_cmd.start_pop  = i_valid && !i_sts.is_push && !i_sts.empty;
            end
            S_PUSH_CHK: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_sel = WR_MOV;
                end else begin
                    o_cmd.rd_sel = RD_PARENT;
                end
            end
            S_PUSH_CMP: begin
                o_cmd.wr_sel = i_sts.parent_wins ? WR_MOV : WR_PARENT;
            end
            S_POP_LAST_RD: begin
                if (!i_sts.empty) begin
                    o_cmd.rd_sel = RD_LAST;
                end
            end
            S_POP_LAST_WAIT: begin
                o_cmd.load_mov = 1'b1;
            end
            S_POP_CHK: begin
                if (i_sts.no_left) begin
                    o_cmd.wr_sel = WR_MOV;
                end else begin
                    o_cmd.rd_sel = RD_LEFT;
                end
            end
            S_POP_R_RD: begin
                o_cmd.load_left = 1'b1;
                o_cmd.rd_sel    = RD_RIGHT;
            end
            S_POP_CMP: begin
                o_cmd.wr_sel = i_sts.child_wins ? WR_CHILD : WR_MOV;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/bmhq_dp.sv @@
`timescale 1ns / 1ps

`include "binary_max_heap_queue_top_defines.svh"

module bmhq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bmhq_pkg::t_in_item  i_item,
    input  bmhq_pkg::t_dp_cmd   i_cmd,
    output bmhq_pkg::t_dp_sts   o_sts,
    output logic                o_valid,
    input  logic                i_ready,
    output bmhq_pkg::t_out_item o_result
);

    import bmhq_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    t_entry            r_mov;
    t_entry            n_mov;
    t_entry            r_left;
    t_entry            r_top;
    logic [1:0]        r_status;
    t_out_item         r_out;
    logic              r_out_valid;
    logic              n_out_valid;

    t_entry            w_rdata;
    t_entry            w_wdata;
    t_entry            w_child;
    logic              w_we;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_parent;
    logic [IDX_W-1:0]  w_l_idx;
    logic [IDX_W-1:0]  w_r_idx;
    logic              w_left_wins;
    logic              w_right_wins;
    t_entry            w_best;
    logic [ADDR_W-1:0] w_child_idx;
    t_out_item         w_result;

    assign w_parent = (r_pos - ADDR_W'(1)) >> 1;
    assign w_l_idx  = {1'b0, r_pos, 1'b1};
    assign w_r_idx  = w_l_idx + IDX_W'(1);

    // pop descent: left beats the moving entry only if strictly larger, right beats the best so far
    assign w_left_wins  = $signed(r_left.pri) > $signed(r_mov.pri);
    assign w_best       = w_left_wins ? r_left : r_mov;
    assign w_right_wins = (w_r_idx < IDX_W'(r_count)) &&
                          ($signed(w_rdata.pri) > $signed(w_best.pri));
    assign w_child      = w_right_wins ? w_rdata : r_left;
    assign w_child_idx  = w_right_wins ? ADDR_W'(w_r_idx) : ADDR_W'(w_l_idx);

    always_comb begin
        w_raddr = '0;
        unique case (i_cmd.rd_sel)
            RD_NONE:   w_raddr = '0;
            RD_PARENT: w_raddr = w_parent;
            RD_LAST:   w_raddr = ADDR_W'(r_count);
            RD_LEFT:   w_raddr = ADDR_W'(w_l_idx);
            RD_RIGHT:  w_raddr = ADDR_W'(w_r_idx);
            default:   w_raddr = '0;
        endcase
    end

    always_comb begin
        w_wdata = r_mov;
        unique case (i_cmd.wr_sel)
            WR_NONE:   w_wdata = r_mov;
            WR_MOV:    w_wdata = r_mov;
            WR_PARENT: w_wdata = w_rdata;
            WR_CHILD:  w_wdata = w_child;
            default:   w_wdata = r_mov;
        endcase
    end

    assign w_we = i_cmd.wr_sel != WR_NONE;
    assign w_re = i_cmd.rd_sel != RD_NONE;

    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_mov   = r_mov;
        if (i_cmd.start_push) begin
            n_count   = r_count + CNT_W'(1);
            n_pos     = ADDR_W'(r_count);
            n_mov.pri = i_item.priority_req;
            n_mov.pay = i_item.payload;
        end
        if (i_cmd.start_pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.load_mov) begin
            n_mov = w_rdata;
            n_pos = '0;
        end
        if (i_cmd.wr_sel == WR_PARENT) begin
            n_pos = w_parent;
        end
        if (i_cmd.wr_sel == WR_CHILD) begin
            n_pos = w_child_idx;
        end
    end

    always_comb begin
        w_result.top_valid    = r_count != '0;
        w_result.top_payload  = (r_count != '0) ? r_top.pay : '0;
        w_result.top_priority = (r_count != '0) ? r_top.pri : '0;
        w_result.entry_count  = OUT_CNT_W'(r_count);
        w_result.status       = r_status;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_mov <= n_mov;
        if (i_cmd.load_left) begin
            r_left <= w_rdata;
        end
        // root copy for the result
        if (w_we && (r_pos == '0)) begin
            r_top <= w_wdata;
        end
        if (i_cmd.accept) begin
            if (i_item.command == CMD_PUSH) begin
                r_status <= (r_count == CNT_W'(CAPACITY)) ? ST_FULL : ST_DONE;
            end else begin
                r_status <= (r_count == '0) ? ST_EMPTY : ST_DONE;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= w_result;
        end
    end

    assign o_sts.is_push     = i_item.command == CMD_PUSH;
    assign o_sts.full        = r_count == CNT_W'(CAPACITY);
    assign o_sts.empty       = r_count == '0;
    assign o_sts.pos_zero    = r_pos == '0;
    assign o_sts.parent_wins = $signed(w_rdata.pri) > $signed(r_mov.pri);
    assign o_sts.no_left     = w_l_idx >= IDX_W'(r_count);
    assign o_sts.child_wins  = w_left_wins || w_right_wins;
    assign o_sts.out_free    = !r_out_valid || i_ready;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `BMHQ_ASSERT_NOW(a_write_in_range, w_we, CNT_W'(r_pos) < r_count,
        "store write outside the filled region")
    `BMHQ_ASSERT_NOW(a_out_slot_free, i_cmd.out_load, !r_out_valid || i_ready,
        "result overwrites an untaken transfer")
    `BMHQ_ASSERT_NEXT(a_count_hold, !(i_cmd.start_push || i_cmd.start_pop),
        $stable(r_count), "entry count changed without an operation")

endmodule

@@ sv/binary_max_heap_queue_top.sv @@
`timescale 1ns / 1ps

// channel   handshake          payload                     direction
// input     i_valid / o_ready  i_item   (t_in_item)        in
// output    o_valid / i_ready  o_result (t_out_item)       out
//
// one item at a time; o_ready is high only in idle, the first cycle of each item
// push climbs by check and compare per level; stops at the root or when a parent wins
// pop: load last entry, done if it was the only one; per level read left, right, compare
// rejected push (full) or pop (empty) skips to done; one store read port sets the pace
// a result waits in the output register while the next item runs; done stalls until taken
// synchronous active-low reset empties the queue; store contents need no clearing

module binary_max_heap_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bmhq_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output bmhq_pkg::t_out_item o_result
);

    import bmhq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bmhq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    bmhq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

@@ test/bmhq_checker.sv @@
`timescale 1ns / 1ps

module bmhq_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  bmhq_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  bmhq_pkg::t_out_item i_out_item,
    output int                  o_err_count,
    output int                  o_pending
);

    import bmhq_pkg::*;

    t_entry    heap_mem [CAPACITY];
    int        heap_fill = 0;
    t_out_item expected_tops [$];
    int        mismatches = 0;

    function automatic t_out_item heap_apply(input t_in_item it);
        t_out_item res;
        t_entry    tmp;
        int        pos;
        int        up;
        int        l;
        int        r;
        int        best;
        res        = '0;
        res.status = ST_DONE;
        if (it.command == CMD_PUSH) begin
            if (heap_fill >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos           = heap_fill;
                heap_mem[pos] = {it.priority_req, it.payload};
                heap_fill++;
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if ($signed(heap_mem[up].pri) > $signed(heap_mem[pos].pri))
                        break;
                    tmp           = heap_mem[up];
                    heap_mem[up]  = heap_mem[pos];
                    heap_mem[pos] = tmp;
                    pos           = up;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                heap_fill--;
                heap_mem[0] = heap_mem[heap_fill];
                pos         = 0;
                forever begin
                    l    = 2 * pos + 1;
                    r    = 2 * pos + 2;
                    best = pos;
                    if (l < heap_fill &&
                        $signed(heap_mem[l].pri) > $signed(heap_mem[best].pri))
                        best = l;
                    if (r < heap_fill &&
                        $signed(heap_mem[r].pri) > $signed(heap_mem[best].pri))
                        best = r;
                    if (best == pos)
                        break;
                    tmp            = heap_mem[pos];
                    heap_mem[pos]  = heap_mem[best];
                    heap_mem[best] = tmp;
                    pos            = best;
                end
            end
        end
        if (heap_fill > 0) begin
            res.top_valid    = 1'b1;
            res.top_payload  = heap_mem[0].pay;
            res.top_priority = heap_mem[0].pri;
        end
        res.entry_count = OUT_CNT_W'(heap_fill);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v, inout bit bad);
        if (act_v !== exp_v) begin
            bad = 1'b1;
            if (mismatches < 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        bit        bad;
        if (!i_rst_n) begin
            heap_fill = 0;
            expected_tops.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_tops.push_back(heap_apply(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (expected_tops.size() == 0) begin
                    if (mismatches < 40)
                        $display("%0t: unexpected result transfer, expected none, actual %0h",
                                 $time, i_out_item);
                    mismatches++;
                end else begin
                    want = expected_tops.pop_front();
                    bad  = 1'b0;
                    check_field("top_valid", 32'(want.top_valid),
                                32'(i_out_item.top_valid), bad);
                    check_field("top_payload", want.top_payload, i_out_item.top_payload,
                                bad);
                    check_field("top_priority", 32'(want.top_priority),
                                32'(i_out_item.top_priority), bad);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(i_out_item.entry_count), bad);
                    check_field("status", 32'(want.status), 32'(i_out_item.status), bad);
                    if (bad)
                        mismatches++;
                end
            end
        end
        o_err_count <= mismatches;
        o_pending   <= expected_tops.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bmhq_pkg::*;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_result;

    int err_count;
    int pending;
    int send_idle = 33;
    int rcv_idle  = 70;

    binary_max_heap_queue_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    bmhq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_item   (i_item),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_item  (o_result),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_op(input logic cmd, input logic [31:0] pay, input logic [15:0] pri);
        t_in_item it;
        it.command      = cmd;
        it.payload      = pay;
        it.priority_req = pri;
        send_item(it);
    endtask

    function automatic t_in_item rand_item(input int push_pct);
        t_in_item it;
        it.command = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
        it.payload = $urandom;
        case ($urandom_range(2))
            0: it.priority_req = 16'($urandom);
            1: it.priority_req = 16'($urandom_range(8)) - 16'd4;
            default: begin
                case ($urandom_range(3))
                    0: it.priority_req = 16'h8000;
                    1: it.priority_req = 16'h7fff;
                    2: it.priority_req = 16'h0000;
                    default: it.priority_req = 16'hffff;
                endcase
            end
        endcase
        return it;
    endfunction

    task automatic run_phase(input int s_idle, input int r_idle, input int n_items);
        int sent;
        int run_len;
        int push_pct;
        send_idle = s_idle;
        rcv_idle  = r_idle;
        sent      = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(160, 40);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                send_item(rand_item(push_pct));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, extremes, ties on the way up
        send_op(CMD_POP, 32'hffff_ffff, 16'h7fff);
        send_op(CMD_PUSH, 32'h0000_0000, 16'h0000);
        send_op(CMD_PUSH, 32'hffff_ffff, 16'h7fff);
        send_op(CMD_PUSH, 32'h0000_0001, 16'h8000);
        send_op(CMD_PUSH, 32'h0000_0002, 16'h7fff);
        send_op(CMD_PUSH, 32'h0000_0003, 16'h7fff);
        send_op(CMD_PUSH, 32'haaaa_aaaa, 16'hffff);
        send_op(CMD_PUSH, 32'h5555_5555, 16'h5555);
        repeat (8) send_op(CMD_POP, $urandom, 16'($urandom));

        // equal children on the way down
        send_op(CMD_PUSH, 32'h0000_0011, 16'd5);
        send_op(CMD_PUSH, 32'h0000_0012, 16'd5);
        send_op(CMD_PUSH, 32'h0000_0013, 16'd5);
        repeat (4) send_op(CMD_POP, $urandom, 16'($urandom));

        run_phase(33, 70, 650);
        run_phase(70, 33, 650);
        run_phase(0, 0, 650);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
